>>> sv/rv32ie_pkg.sv
package rv32ie_pkg;

    // Sizes of the data memory and the program window
    localparam int MEM_BYTES      = 4096;
    localparam int PROG_WORDS_MAX = 1024;

    localparam int XLEN    = 32;
    localparam int REG_N   = 32;
    localparam int REG_AW  = $clog2(REG_N);
    localparam int RD_PORTS = 3;

    // Byte memory is split into four byte lanes, one row holds one word
    localparam int BANKS  = 4;
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / BANKS;
    localparam int ROW_W  = MEM_AW - 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int PC_CFG_W   = 12;
    localparam int PW_W       = 11;
    localparam logic [PW_W-1:0] PW_RST = PW_W'(1024);
    localparam logic [XLEN-1:0] PC_RST = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_WORDS = 1'b1;

    // Stream field and word widths
    localparam int IMM_W  = 21;
    localparam int TGT_W  = 12;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 72;

    typedef enum logic [5:0] {
        OP_ADD    = 6'd0,  OP_SUB   = 6'd1,  OP_SLL   = 6'd2,  OP_SLT   = 6'd3,
        OP_SLTU   = 6'd4,  OP_XOR   = 6'd5,  OP_SRL   = 6'd6,  OP_SRA   = 6'd7,
        OP_OR     = 6'd8,  OP_AND   = 6'd9,  OP_ADDI  = 6'd10, OP_SLTI  = 6'd11,
        OP_SLTIU  = 6'd12, OP_XORI  = 6'd13, OP_ORI   = 6'd14, OP_ANDI  = 6'd15,
        OP_SLLI   = 6'd16, OP_SRLI  = 6'd17, OP_SRAI  = 6'd18, OP_JALR  = 6'd19,
        OP_LB     = 6'd20, OP_LH    = 6'd21, OP_LW    = 6'd22, OP_LBU   = 6'd23,
        OP_LHU    = 6'd24, OP_SB    = 6'd25, OP_SH    = 6'd26, OP_SW    = 6'd27,
        OP_BEQ    = 6'd28, OP_BNE   = 6'd29, OP_BLT   = 6'd30, OP_BGE   = 6'd31,
        OP_BLTU   = 6'd32, OP_BGEU  = 6'd33, OP_JAL   = 6'd34, OP_LUI   = 6'd35,
        OP_AUIPC  = 6'd36, OP_FENCE = 6'd37, OP_ECALL = 6'd38, OP_EBREAK = 6'd39
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_HALT  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Register file write
    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    // Data memory access, one entry per byte lane
    typedef struct packed {
        logic                        rd_en;
        logic [BANKS-1:0]            wr_en;
        logic [BANKS-1:0][ROW_W-1:0] row;
        logic [BANKS-1:0][7:0]       wdata;
    } dm_req_t;

endpackage

>>> sv/rv32ie_regfile.sv
module rv32ie_regfile import rv32ie_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  logic [RD_PORTS-1:0][REG_AW-1:0]  raddr,
    input  rf_wr_t                           wr,
    output logic [RD_PORTS-1:0][XLEN-1:0]    rdata
);

    // One valid bit per register: an unwritten register reads as zero
    logic [REG_N-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.we) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // One copy of the array per read port; each port keeps its word current
    // with later writes for as long as the reader holds it
    for (genvar p = 0; p < RD_PORTS; p++) begin : g_port
        logic [XLEN-1:0]   mem [REG_N];
        logic [XLEN-1:0]   q_reg;
        logic              q_vld_reg;
        logic [REG_AW-1:0] addr_reg;
        logic              ov_v_reg;
        logic [XLEN-1:0]   ov_reg;
        logic              hit_new;
        logic              hit_held;

        assign hit_new  = rd_en && wr.we && (wr.addr == raddr[p]);
        assign hit_held = !rd_en && wr.we && (wr.addr == addr_reg);

        // Write and registered read of the array
        always_ff @(posedge aclk) begin
            if (wr.we) begin
                mem[wr.addr] <= wr.data;
            end
            if (rd_en) begin
                q_reg    <= mem[raddr[p]];
                addr_reg <= raddr[p];
            end
            if (hit_new || hit_held) begin
                ov_reg <= wr.data;
            end
        end

        // Track whether a write landed after or during the read
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                q_vld_reg <= 1'b0;
                ov_v_reg  <= 1'b0;
            end else if (rd_en) begin
                q_vld_reg <= vld_reg[raddr[p]];
                ov_v_reg  <= hit_new;
            end else if (hit_held) begin
                ov_v_reg  <= 1'b1;
            end
        end

        assign rdata[p] = ov_v_reg ? ov_reg : (q_vld_reg ? q_reg : '0);
    end

endmodule

>>> sv/rv32ie_dmem.sv
module rv32ie_dmem import rv32ie_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dm_req_t                req,
    output logic [BANKS-1:0][7:0]  rdata,
    output logic                   busy
);

    logic [ROW_W-1:0] clr_row_reg;
    logic             busy_reg;

    // Sweep every row to zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_row_reg <= '0;
        end else if (busy_reg) begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;

    // One byte-wide array per lane, one access per lane per cycle
    for (genvar k = 0; k < BANKS; k++) begin : g_bank
        logic [7:0] mem [ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge aclk) begin
            if (busy_reg) begin
                mem[clr_row_reg] <= '0;
            end else if (req.wr_en[k]) begin
                mem[req.row[k]] <= req.wdata[k];
            end
            if (req.rd_en) begin
                q_reg <= mem[req.row[k]];
            end
        end

        assign rdata[k] = q_reg;
    end

endmodule

>>> sv/rv32i_instruction_executor_core.sv
// Executes one decoded RV32I instruction per input word and returns one result word
// (next pc, register write, status) for each. A word can be accepted on every clock
// once the data memory is cleared and while the result side is not stalled: after
// reset the block zeroes every row of the four byte lanes, with s_tready low. Each
// word passes operand read, execute/memory access and load alignment before the
// output register; results of earlier words are forwarded, so dependent instructions
// still issue back to back. Write start_pc (index 0) and program_words (index 1) only
// while no word is in flight.
module rv32i_instruction_executor_core import rv32ie_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Instruction words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // req_type[5:0], dest_reg[10:6], src_reg_a[15:11], src_reg_b[20:16],
    // immediate[41:21], branch_target[53:42], zero fill [55:54]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // next_pc[31:0], reg_written[32], written_reg[37:33], written_value[69:38],
    // status[71:70]
    output logic [M_DATA_W-1:0]   m_tdata
);

    typedef enum logic [2:0] {
        LD_NONE = 3'd0,
        LD_B    = 3'd1,
        LD_H    = 3'd2,
        LD_W    = 3'd3,
        LD_BU   = 3'd4,
        LD_HU   = 3'd5
    } ld_t;

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_ready, s2_free, s1_free, s1_adv, s2_adv, accept;
    logic clr_busy;

    assign out_ready = !out_v_reg || m_tready;
    assign s2_adv    = s2_v_reg && out_ready;
    assign s2_free   = !s2_v_reg || out_ready;
    assign s1_adv    = s1_v_reg && s2_free;
    assign s1_free   = !s1_v_reg || s2_free;
    assign s_tready  = s1_free && !clr_busy;
    assign accept    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration and program counter
    // ------------------------------------------------------------------
    logic [XLEN-1:0] pc_reg;
    logic [PW_W-1:0] pw_reg;
    logic [XLEN-1:0] s1_npc;
    logic            s1_halt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_RST;
            pw_reg <= PW_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_START_PC:   pc_reg <= XLEN'(cfg_data[PC_CFG_W-1:0]);
                    CFG_PROG_WORDS: pw_reg <= cfg_data[PW_W-1:0];
                    default: ;
                endcase
            end
            if (s1_adv && !(cfg_wr_en && cfg_index == CFG_START_PC)) begin
                pc_reg <= s1_npc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture word, read operands
    // ------------------------------------------------------------------
    op_t               s1_op_reg;
    logic [REG_AW-1:0] s1_rd_reg, s1_ra_reg, s1_rb_reg;
    logic [IMM_W-1:0]  s1_imm_reg;
    logic [TGT_W-1:0]  s1_tgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (accept) begin
            s1_v_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg  <= op_t'(s_tdata[5:0]);
            s1_rd_reg  <= s_tdata[10:6];
            s1_ra_reg  <= s_tdata[15:11];
            s1_rb_reg  <= s_tdata[20:16];
            s1_imm_reg <= s_tdata[41:21];
            s1_tgt_reg <= s_tdata[53:42];
        end
    end

    rf_wr_t                            rf_wr;
    logic [RD_PORTS-1:0][REG_AW-1:0]   rf_raddr;
    logic [RD_PORTS-1:0][XLEN-1:0]     rf_rdata;

    assign rf_raddr[0] = s_tdata[15:11];
    assign rf_raddr[1] = s_tdata[20:16];
    assign rf_raddr[2] = s_tdata[10:6];

    rv32ie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .raddr   (rf_raddr),
        .wr      (rf_wr),
        .rdata   (rf_rdata)
    );

    // Forward the result still waiting in stage 2
    logic            s2_wr_reg;
    logic [REG_AW-1:0] s2_rd_reg;
    logic [XLEN-1:0] s2_res;
    logic [XLEN-1:0] opa, opb, opd;

    assign opa = (s2_v_reg && s2_wr_reg && s2_rd_reg == s1_ra_reg) ? s2_res : rf_rdata[0];
    assign opb = (s2_v_reg && s2_wr_reg && s2_rd_reg == s1_rb_reg) ? s2_res : rf_rdata[1];
    assign opd = (s2_v_reg && s2_wr_reg && s2_rd_reg == s1_rd_reg) ? s2_res : rf_rdata[2];

    // ------------------------------------------------------------------
    // Stage 1: execute
    // ------------------------------------------------------------------
    logic [XLEN-1:0] imm32, pc4, addr, s1_val;
    logic [4:0]      sh_r, sh_i;
    logic            s1_wr, taken, is_st;
    ld_t             s1_ld;
    logic [BANKS-1:0] st_mask;
    status_t         s1_status;
    logic [XLEN-1:0] pw_lim;

    assign imm32 = {{(XLEN-IMM_W){s1_imm_reg[IMM_W-1]}}, s1_imm_reg};
    assign pc4   = pc_reg + 32'd4;
    assign addr  = opa + imm32;
    assign sh_r  = opb[4:0];
    assign sh_i  = imm32[4:0];

    always_comb begin
        s1_val  = '0;
        s1_wr   = 1'b0;
        s1_halt = 1'b0;
        taken   = 1'b0;
        s1_npc  = pc4;
        s1_ld   = LD_NONE;
        is_st   = 1'b0;
        st_mask = '0;
        case (s1_op_reg)
            OP_ADD:   begin s1_val = opa + opb;  s1_wr = 1'b1; end
            OP_SUB:   begin s1_val = opa - opb;  s1_wr = 1'b1; end
            OP_SLL:   begin s1_val = opa << sh_r; s1_wr = 1'b1; end
            OP_SLT:   begin s1_val = XLEN'($signed(opa) < $signed(opb)); s1_wr = 1'b1; end
            OP_SLTU:  begin s1_val = XLEN'(opa < opb); s1_wr = 1'b1; end
            OP_XOR:   begin s1_val = opa ^ opb;  s1_wr = 1'b1; end
            OP_SRL:   begin s1_val = opa >> sh_r; s1_wr = 1'b1; end
            OP_SRA:   begin s1_val = $unsigned($signed(opa) >>> sh_r); s1_wr = 1'b1; end
            OP_OR:    begin s1_val = opa | opb;  s1_wr = 1'b1; end
            OP_AND:   begin s1_val = opa & opb;  s1_wr = 1'b1; end
            OP_ADDI:  begin s1_val = opa + imm32; s1_wr = 1'b1; end
            OP_SLTI:  begin s1_val = XLEN'($signed(opa) < $signed(imm32)); s1_wr = 1'b1; end
            OP_SLTIU: begin s1_val = XLEN'(opa < imm32); s1_wr = 1'b1; end
            OP_XORI:  begin s1_val = opa ^ imm32; s1_wr = 1'b1; end
            OP_ORI:   begin s1_val = opa | imm32; s1_wr = 1'b1; end
            OP_ANDI:  begin s1_val = opa & imm32; s1_wr = 1'b1; end
            OP_SLLI:  begin s1_val = opa << sh_i; s1_wr = 1'b1; end
            OP_SRLI:  begin s1_val = opa >> sh_i; s1_wr = 1'b1; end
            OP_SRAI:  begin s1_val = $unsigned($signed(opa) >>> sh_i); s1_wr = 1'b1; end
            OP_JALR:  begin
                s1_val = pc4;
                s1_wr  = 1'b1;
                s1_npc = {addr[XLEN-1:1], 1'b0};
            end
            OP_LB:    begin s1_wr = 1'b1; s1_ld = LD_B;  end
            OP_LH:    begin s1_wr = 1'b1; s1_ld = LD_H;  end
            OP_LW:    begin s1_wr = 1'b1; s1_ld = LD_W;  end
            OP_LBU:   begin s1_wr = 1'b1; s1_ld = LD_BU; end
            OP_LHU:   begin s1_wr = 1'b1; s1_ld = LD_HU; end
            OP_SB:    begin is_st = 1'b1; st_mask = 4'b0001; end
            OP_SH:    begin is_st = 1'b1; st_mask = 4'b0011; end
            OP_SW:    begin is_st = 1'b1; st_mask = 4'b1111; end
            OP_BEQ:   taken = (opa == opb);
            OP_BNE:   taken = (opa != opb);
            OP_BLT:   taken = ($signed(opa) < $signed(opb));
            OP_BGE:   taken = !($signed(opa) < $signed(opb));
            OP_BLTU:  taken = (opa < opb);
            OP_BGEU:  taken = (opa >= opb);
            OP_JAL:   begin
                s1_val = pc4;
                s1_wr  = 1'b1;
                s1_npc = XLEN'(s1_tgt_reg);
            end
            OP_LUI:   begin s1_val = imm32 << 12; s1_wr = 1'b1; end
            OP_AUIPC: begin s1_val = (imm32 << 12) + pc_reg; s1_wr = 1'b1; end
            OP_FENCE, OP_ECALL, OP_EBREAK: begin
                s1_halt = 1'b1;
                s1_npc  = pc_reg;
            end
            default: ;
        endcase
        if (taken) begin
            s1_npc = XLEN'(s1_tgt_reg);
        end
        // x0 is never written
        if (s1_rd_reg == '0) begin
            s1_wr = 1'b0;
            s1_ld = LD_NONE;
        end
        if (!s1_wr) begin
            s1_val = '0;
        end
    end

    // Status against the clamped program length
    assign pw_lim = (XLEN'(pw_reg) > XLEN'(PROG_WORDS_MAX)) ? XLEN'(PROG_WORDS_MAX)
                                                            : XLEN'(pw_reg);

    always_comb begin
        if (s1_halt) begin
            s1_status = ST_HALT;
        end else if (s1_npc >= (pw_lim << 2)) begin
            s1_status = ST_RANGE;
        end else begin
            s1_status = ST_RUN;
        end
    end

    // Data memory request: lane k takes byte (k - addr[1:0]) of the access
    dm_req_t               dm_req;
    logic [BANKS-1:0][7:0] dm_rdata;
    logic [ROW_W-1:0]      row0;

    assign row0 = addr[MEM_AW-1:2];

    always_comb begin
        logic [1:0] ofs;
        dm_req.rd_en = s1_adv && (s1_ld != LD_NONE);
        for (int k = 0; k < BANKS; k++) begin
            ofs               = 2'(k) - addr[1:0];
            dm_req.row[k]     = (2'(k) >= addr[1:0]) ? row0 : row0 + 1'b1;
            dm_req.wr_en[k]   = s1_adv && is_st && st_mask[ofs];
            dm_req.wdata[k]   = opd[{ofs, 3'b000} +: 8];
        end
    end

    rv32ie_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dm_req),
        .rdata   (dm_rdata),
        .busy    (clr_busy)
    );

    // ------------------------------------------------------------------
    // Stage 2: align load data
    // ------------------------------------------------------------------
    logic [XLEN-1:0] s2_npc_reg, s2_val_reg;
    ld_t             s2_ld_reg;
    logic [1:0]      s2_lo_reg;
    status_t         s2_status_reg;
    logic [XLEN-1:0] ld_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (s1_adv) begin
            s2_v_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_npc_reg    <= s1_npc;
            s2_wr_reg     <= s1_wr;
            s2_rd_reg     <= s1_wr ? s1_rd_reg : '0;
            s2_val_reg    <= s1_val;
            s2_ld_reg     <= s1_ld;
            s2_lo_reg     <= addr[1:0];
            s2_status_reg <= s1_status;
        end
    end

    // Rotate the lanes so byte 0 of the access sits lowest
    always_comb begin
        logic [1:0] lane;
        for (int i = 0; i < BANKS; i++) begin
            lane               = 2'(i) + s2_lo_reg;
            ld_word[8*i +: 8]  = dm_rdata[lane];
        end
    end

    always_comb begin
        case (s2_ld_reg)
            LD_B:    s2_res = {{24{ld_word[7]}}, ld_word[7:0]};
            LD_H:    s2_res = {{16{ld_word[15]}}, ld_word[15:0]};
            LD_W:    s2_res = ld_word;
            LD_BU:   s2_res = {24'd0, ld_word[7:0]};
            LD_HU:   s2_res = {16'd0, ld_word[15:0]};
            default: s2_res = s2_val_reg;
        endcase
    end

    // Commit the register write as the result moves to the output
    assign rf_wr.we   = s2_adv && s2_wr_reg;
    assign rf_wr.addr = s2_rd_reg;
    assign rf_wr.data = s2_res;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [XLEN-1:0]   out_npc_reg, out_val_reg;
    logic              out_wr_reg;
    logic [REG_AW-1:0] out_rd_reg;
    status_t           out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (s2_adv) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            out_npc_reg    <= s2_npc_reg;
            out_wr_reg     <= s2_wr_reg;
            out_rd_reg     <= s2_rd_reg;
            out_val_reg    <= s2_res;
            out_status_reg <= s2_status_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_status_reg, out_val_reg, out_rd_reg, out_wr_reg, out_npc_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_clr_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("word accepted while data memory is being cleared");

    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.we |-> (rf_wr.addr != '0))
        else $error("register file write to x0");

    a_s2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_v_reg && !out_ready) |=> s2_v_reg)
        else $error("stage 2 result dropped while output stalled");

    a_halt_keeps_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_halt && !cfg_wr_en) |=> (pc_reg == $past(pc_reg)))
        else $error("system instruction moved the program counter");

endmodule

>>> tb/sv/rv32_shadow_pkg.sv
package rv32_shadow_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32ie_pkg::*;

    // One decoded instruction as it travels on the input stream
    typedef struct {
        logic [5:0]              op;
        logic [REG_AW-1:0]       rd;
        logic [REG_AW-1:0]       rs1;
        logic [REG_AW-1:0]       rs2;
        logic signed [IMM_W-1:0] imm;
        logic [TGT_W-1:0]        tgt;
    } instr_t;

    // One retired instruction as it leaves on the result stream
    typedef struct {
        logic [XLEN-1:0]   next_pc;
        logic              wr;
        logic [REG_AW-1:0] wreg;
        logic [XLEN-1:0]   wval;
        logic [1:0]        status;
    } retire_t;

    // Shadow copy of the executor: architectural state, retire queue and checker
    class rv32_shadow_core;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] xreg [REG_N];
        logic [7:0]      dmem [MEM_BYTES];
        logic [PW_W-1:0] prog_words;
        retire_t         retire_q [$];
        int              mismatches;

        function new();
            pc         = PC_RST;
            prog_words = PW_RST;
            mismatches = 0;
            foreach (xreg[i]) xreg[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
        endfunction

        function int outstanding();
            return retire_q.size();
        endfunction

        // Apply a configuration write; start_pc reloads the program counter
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_START_PC) begin
                pc = XLEN'(val[PC_CFG_W-1:0]);
            end else begin
                prog_words = val[PW_W-1:0];
            end
        endfunction

        // Little-endian access, each byte address wrapping within the memory
        function logic [XLEN-1:0] load_bytes(logic [XLEN-1:0] addr, int n);
            logic [XLEN-1:0]   v;
            logic [MEM_AW-1:0] ba;
            v = '0;
            for (int i = 0; i < n; i++) begin
                ba = MEM_AW'(addr + i);
                v[8*i +: 8] = dmem[ba];
            end
            return v;
        endfunction

        function void store_bytes(logic [XLEN-1:0] addr, logic [XLEN-1:0] v, int n);
            logic [MEM_AW-1:0] ba;
            for (int i = 0; i < n; i++) begin
                ba = MEM_AW'(addr + i);
                dmem[ba] = v[8*i +: 8];
            end
        endfunction

        // Execute one accepted instruction and queue the word it must retire
        function void note_instr(instr_t it);
            logic [XLEN-1:0] a, b, immx, npc, addr, val, word;
            logic            wr, halt, taken;
            int unsigned     lim;
            retire_t         r;
            a     = xreg[it.rs1];
            b     = xreg[it.rs2];
            immx  = {{(XLEN-IMM_W){it.imm[IMM_W-1]}}, it.imm};
            npc   = pc + 4;
            addr  = a + immx;
            val   = '0;
            wr    = 1'b1;
            halt  = 1'b0;
            taken = 1'b0;
            case (it.op)
                OP_ADD:   val = a + b;
                OP_SUB:   val = a - b;
                OP_SLL:   val = a << b[4:0];
                OP_SLT:   val = XLEN'($signed(a) < $signed(b));
                OP_SLTU:  val = XLEN'(a < b);
                OP_XOR:   val = a ^ b;
                OP_SRL:   val = a >> b[4:0];
                OP_SRA:   val = $signed(a) >>> b[4:0];
                OP_OR:    val = a | b;
                OP_AND:   val = a & b;
                OP_ADDI:  val = a + immx;
                OP_SLTI:  val = XLEN'($signed(a) < $signed(immx));
                OP_SLTIU: val = XLEN'(a < immx);
                OP_XORI:  val = a ^ immx;
                OP_ORI:   val = a | immx;
                OP_ANDI:  val = a & immx;
                OP_SLLI:  val = a << immx[4:0];
                OP_SRLI:  val = a >> immx[4:0];
                OP_SRAI:  val = $signed(a) >>> immx[4:0];
                OP_JALR: begin
                    val = pc + 4;
                    npc = {addr[XLEN-1:1], 1'b0};
                end
                OP_LB: begin
                    word = load_bytes(addr, 1);
                    val  = {{24{word[7]}}, word[7:0]};
                end
                OP_LH: begin
                    word = load_bytes(addr, 2);
                    val  = {{16{word[15]}}, word[15:0]};
                end
                OP_LW:    val = load_bytes(addr, 4);
                OP_LBU:   val = load_bytes(addr, 1);
                OP_LHU:   val = load_bytes(addr, 2);
                OP_SB, OP_SH, OP_SW: begin
                    // store data comes from the register named in the rd slot
                    wr = 1'b0;
                    store_bytes(addr, xreg[it.rd],
                                (it.op == OP_SB) ? 1 : (it.op == OP_SH) ? 2 : 4);
                end
                OP_BEQ:  begin wr = 1'b0; taken = (a == b); end
                OP_BNE:  begin wr = 1'b0; taken = (a != b); end
                OP_BLT:  begin wr = 1'b0; taken = ($signed(a) < $signed(b)); end
                OP_BGE:  begin wr = 1'b0; taken = ($signed(a) >= $signed(b)); end
                OP_BLTU: begin wr = 1'b0; taken = (a < b); end
                OP_BGEU: begin wr = 1'b0; taken = (a >= b); end
                OP_JAL: begin
                    val = pc + 4;
                    npc = XLEN'(it.tgt);
                end
                OP_LUI:   val = immx << 12;
                OP_AUIPC: val = (immx << 12) + pc;
                OP_FENCE, OP_ECALL, OP_EBREAK: begin
                    wr   = 1'b0;
                    halt = 1'b1;
                    npc  = pc;
                end
                // undefined codes just fall through to the next word
                default:  wr = 1'b0;
            endcase
            if (taken) npc = XLEN'(it.tgt);
            if (it.rd == '0) wr = 1'b0;
            if (wr) xreg[it.rd] = val;
            pc = npc;

            lim       = (prog_words > PROG_WORDS_MAX) ? PROG_WORDS_MAX : prog_words;
            r.next_pc = npc;
            r.wr      = wr;
            r.wreg    = wr ? it.rd : '0;
            r.wval    = wr ? val : '0;
            r.status  = halt ? ST_HALT : ((npc >= lim * 4) ? ST_RANGE : ST_RUN);
            retire_q.insert(retire_q.size(), r);
        endfunction

        function void compare(string field, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Check one retired word against the oldest queued expectation
        function void check_result(logic [M_DATA_W-1:0] d);
            retire_t want;
            if (retire_q.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, d);
                mismatches++;
                return;
            end
            want = retire_q.pop_front();
            compare("next_pc", want.next_pc, d[31:0]);
            compare("reg_written", XLEN'(want.wr), XLEN'(d[32]));
            compare("written_reg", XLEN'(want.wreg), XLEN'(d[37:33]));
            compare("written_value", want.wval, d[69:38]);
            compare("status", XLEN'(want.status), XLEN'(d[71:70]));
        endfunction
    endclass

endpackage

>>> tb/sv/rv32i_instruction_executor_core_tb.sv
module rv32i_instruction_executor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32ie_pkg::*;
    import rv32_shadow_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 6;
    localparam int WORDS_PER_PHASE = 316;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Codes past the last defined operation
    localparam logic [5:0] OP_UNDEF_LO = 6'd40;
    localparam logic [5:0] OP_UNDEF_HI = 6'd63;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int send_gap_pct   = 0;
    int accept_gap_pct = 0;

    rv32_shadow_core shadow;

    rv32i_instruction_executor_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= accept_gap_pct);
    end

    // Check every result word taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_result(m_tdata);
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Present one word, idling first at random; entered and left at a falling edge
    task automatic send_word(input instr_t it);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.tgt, it.imm, it.rs2, it.rs1, it.rd, it.op};
        do @(posedge aclk); while (!s_tready);
        shadow.note_instr(it);
        @(negedge aclk);
    endtask

    task automatic issue(input logic [5:0] op, input int rd, input int rs1, input int rs2,
                         input int imm, input int tgt);
        instr_t it;
        it.op  = op;
        it.rd  = REG_AW'(rd);
        it.rs1 = REG_AW'(rs1);
        it.rs2 = REG_AW'(rs2);
        it.imm = IMM_W'(imm);
        it.tgt = TGT_W'(tgt);
        send_word(it);
    endtask

    // Drop valid and hold until every retired word has been checked
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write both registers back to back
    task automatic set_config(input int unsigned start_addr, input int unsigned words);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_PC;
        cfg_data  <= CFG_DATA_W'(start_addr);
        @(posedge aclk);
        shadow.write_reg(CFG_START_PC, CFG_DATA_W'(start_addr));
        @(negedge aclk);
        cfg_index <= CFG_PROG_WORDS;
        cfg_data  <= CFG_DATA_W'(words);
        @(posedge aclk);
        shadow.write_reg(CFG_PROG_WORDS, CFG_DATA_W'(words));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly the low registers, so results feed straight into the next word
    function automatic logic [REG_AW-1:0] pick_reg();
        if ($urandom_range(9) < 7) return REG_AW'($urandom_range(7));
        return REG_AW'($urandom);
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) return IMM_W'($urandom);
        if (sel < 30) begin
            case ($urandom_range(3))
                0:       return {1'b1, {(IMM_W-1){1'b0}}};
                1:       return {1'b0, {(IMM_W-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return IMM_W'(int'($urandom_range(127)) - 64);
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        it.rd  = pick_reg();
        it.rs1 = pick_reg();
        it.rs2 = pick_reg();
        it.imm = pick_imm();
        it.tgt = TGT_W'($urandom);
        pick   = $urandom_range(99);
        if (pick < 25) begin
            it.op = 6'($urandom_range(OP_ADD, OP_AND));
        end else if (pick < 45) begin
            it.op = 6'($urandom_range(OP_ADDI, OP_SRAI));
        end else if (pick < 70) begin
            it.op = 6'($urandom_range(OP_LB, OP_SW));
            // keep most accesses in a small shared window so loads see stores
            if ($urandom_range(9) < 6) begin
                it.rs1 = '0;
                it.imm = IMM_W'($urandom_range(63));
            end
        end else if (pick < 80) begin
            it.op = 6'($urandom_range(OP_BEQ, OP_BGEU));
            if ($urandom_range(9) < 3) it.rs2 = it.rs1;
        end else if (pick < 86) begin
            it.op = $urandom_range(1) ? OP_JAL : OP_JALR;
        end else if (pick < 91) begin
            it.op = 6'($urandom_range(OP_LUI, OP_AUIPC));
        end else if (pick < 95) begin
            it.op = 6'($urandom_range(OP_FENCE, OP_EBREAK));
        end else begin
            it.op = 6'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end
        return it;
    endfunction

    initial begin
        shadow = new();
        send_gap_pct   = 37;
        accept_gap_pct = 84;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under reset configuration
        issue(OP_ADDI,   1, 0, 0, -1048576, 0);
        issue(OP_ADDI,   2, 0, 0, 1048575, 0);
        issue(OP_LUI,    3, 0, 0, -1, 0);
        issue(OP_ADDI,   4, 0, 0, 33, 0);
        // shift amounts above 31 keep only their low five bits
        issue(OP_SLL,    5, 2, 4, 0, 0);
        issue(OP_SRA,    6, 3, 4, 0, 0);
        issue(OP_SRL,    7, 3, 4, 0, 0);
        issue(OP_SLT,    8, 3, 2, 0, 0);
        issue(OP_SLTU,   9, 3, 2, 0, 0);
        issue(OP_SLTIU, 10, 2, 0, -1, 0);
        issue(OP_SRAI,  11, 3, 0, 1048575, 0);
        // word straddling the top of memory wraps to address zero
        issue(OP_SW,     3, 0, 0, 4094, 0);
        issue(OP_LW,    12, 0, 0, 4094, 0);
        issue(OP_LB,    13, 0, 0, 4095, 0);
        issue(OP_LHU,   14, 0, 0, -4096, 0);
        issue(OP_LH,    15, 0, 0, 0, 0);
        issue(OP_SB,     2, 0, 0, -1, 0);
        issue(OP_LBU,   16, 0, 0, 4095, 0);
        issue(OP_BLTU,   0, 2, 3, 0, 256);
        issue(OP_BGE,    0, 2, 3, 0, 4095);
        issue(OP_BNE,    0, 0, 0, 0, 4095);
        // jump to address zero is still taken
        issue(OP_JAL,   31, 0, 0, 0, 0);
        // jalr reads its base before overwriting it, and drops bit zero
        issue(OP_JALR,  17, 2, 0, 0, 0);
        issue(OP_JALR,   2, 2, 0, 2, 0);
        issue(OP_AUIPC, 18, 0, 0, -1048576, 0);
        issue(OP_ECALL,  0, 0, 0, 0, 0);
        issue(OP_UNDEF_HI, 5, 1, 2, 0, 0);
        issue(OP_ADDI,   0, 1, 0, 5, 0);

        // Random phases, each with its own configuration; the idling pattern changes at phases 2 and 4
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                send_gap_pct   = 84;
                accept_gap_pct = 37;
            end else if (ph == 4) begin
                send_gap_pct   = 0;
                accept_gap_pct = 0;
            end
            wait_idle();
            case (ph)
                0:       set_config(4092, 0);
                2:       set_config(0, 1024);
                5:       set_config(4092, 1024);
                default: set_config($urandom_range(4092), $urandom_range(1024));
            endcase
            repeat (WORDS_PER_PHASE) send_word(random_instr());
        end

        wait_idle();
        if (shadow.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rv32ie_pkg.sv
sv/rv32ie_regfile.sv
sv/rv32ie_dmem.sv
sv/rv32i_instruction_executor_core.sv
tb/sv/rv32_shadow_pkg.sv
tb/sv/rv32i_instruction_executor_core_tb.sv
